// ----- src/btb_pkg.sv -----
// shared types and constants for the branch target buffer predictor
package btb_pkg;

  // address increment on a miss
  localparam int unsigned STEP_BYTES = 4;

  // number of chain outputs on the top level
  localparam int unsigned NUM_OUT = 5;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_UPDATE
  } btb_state_t;

  // lookup status from the entry row
  typedef struct packed {
    logic hit;
    logic hit_exec;
  } btb_lookup_t;

  // update command to the entry row
  typedef struct packed {
    logic write;
    logic flush;
  } btb_update_t;

endpackage

// ----- src/btb_cell.sv -----
// one buffer entry: holds a pair, compares it, takes its neighbor's entry on a shift
module btb_cell #(
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ADDR_BITS-1:0] lookup_addr,
  input  logic                 shift,
  input  logic                 flush,
  input  logic [ADDR_BITS-1:0] prev_source,
  input  logic [ADDR_BITS-1:0] prev_target,
  input  logic                 prev_exec,
  input  logic                 prev_valid,
  output logic [ADDR_BITS-1:0] source,
  output logic [ADDR_BITS-1:0] target,
  output logic                 from_exec,
  output logic                 valid,
  output logic                 match
);

  // valid bit, cleared by reset and flush
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (flush) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift) begin
      source    <= prev_source;
      target    <= prev_target;
      from_exec <= prev_exec;
    end
  end

  // address compare
  assign match = valid && (source == lookup_addr);

endmodule

// ----- src/btb_row.sv -----
// row of entry cells with priority hit select and shift control
module btb_row #(
  parameter int ENTRIES   = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ADDR_BITS-1:0]   lookup_addr,
  input  logic [ADDR_BITS-1:0]   wr_source,
  input  logic [ADDR_BITS-1:0]   wr_target,
  input  logic                   wr_exec,
  input  btb_pkg::btb_update_t   update,
  output btb_pkg::btb_lookup_t   status,
  output logic [ADDR_BITS-1:0]   hit_target
);

  logic [ADDR_BITS-1:0] src   [ENTRIES];
  logic [ADDR_BITS-1:0] tgt   [ENTRIES];
  logic [ENTRIES-1:0]   exec_vec;
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   hit_vec;
  logic [ENTRIES-1:0]   hit_oh;
  logic [ENTRIES-1:0]   shift_mask;
  logic [ENTRIES-1:0]   shift_en;

  // the chain of cells, cell 0 takes the new pair
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [ADDR_BITS-1:0] in_src;
    logic [ADDR_BITS-1:0] in_tgt;
    logic                 in_exec;
    logic                 in_valid;

    if (i == 0) begin : g_head
      assign in_src   = wr_source;
      assign in_tgt   = wr_target;
      assign in_exec  = wr_exec;
      assign in_valid = 1'b1;
    end else begin : g_body
      assign in_src   = src[i-1];
      assign in_tgt   = tgt[i-1];
      assign in_exec  = exec_vec[i-1];
      assign in_valid = valid_vec[i-1];
    end

    btb_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .lookup_addr(lookup_addr),
      .shift      (shift_en[i]),
      .flush      (update.flush),
      .prev_source(in_src),
      .prev_target(in_tgt),
      .prev_exec  (in_exec),
      .prev_valid (in_valid),
      .source     (src[i]),
      .target     (tgt[i]),
      .from_exec  (exec_vec[i]),
      .valid      (valid_vec[i]),
      .match      (hit_vec[i])
    );
  end

  // lowest-index hit as a one-hot vector
  assign hit_oh = hit_vec & (~hit_vec + ENTRIES'(1));

  // cells at or below the hit shift; all of them on a miss
  assign shift_mask = (|hit_vec) ? (hit_oh | (hit_oh - ENTRIES'(1))) : '1;
  assign shift_en   = update.write ? shift_mask : '0;

  // and-or select of the hit entry
  always_comb begin
    hit_target = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_target = hit_target | tgt[i];
      end
    end
  end

  assign status.hit      = |hit_vec;
  assign status.hit_exec = |(hit_oh & exec_vec);

endmodule

// ----- src/branch_target_buffer_predictor.sv -----
// top level: request sequencer, prediction chain walk and result register
// A request is captured, then walked with CHAIN_DEPTH - 1 lookups in the shared entry row
// (one chain address per cycle, each depending on the last), and then the update state
// looks up write_source and applies the insert or flush. All predictions see the
// buffer as it stood before the request. The result register frees the sequencer once
// loaded, so a new request is taken in the cycle after the update even if the result waits;
// the update cycle itself holds while the previous result has not been taken. The buffer
// is a row of ENTRIES cells in most-recent-first order that shift toward the end on insert.
module branch_target_buffer_predictor #(
  parameter int ENTRIES     = 8,
  parameter int CHAIN_DEPTH = 5,
  parameter int ADDR_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 flush,
  input  logic                 write_enable,
  input  logic                 write_from_exec,
  input  logic [ADDR_BITS-1:0] write_source,
  input  logic [ADDR_BITS-1:0] write_target,
  input  logic [ADDR_BITS-1:0] fetch_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_BITS-1:0] predicted_0,
  output logic [ADDR_BITS-1:0] predicted_1,
  output logic [ADDR_BITS-1:0] predicted_2,
  output logic [ADDR_BITS-1:0] predicted_3,
  output logic [ADDR_BITS-1:0] predicted_4
);

  localparam int STEP_W = (CHAIN_DEPTH > 2) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int NOUT   = int'(btb_pkg::NUM_OUT);

  btb_pkg::btb_state_t   state;
  btb_pkg::btb_state_t   state_next;
  btb_pkg::btb_lookup_t  status;
  btb_pkg::btb_update_t  update;

  logic [STEP_W-1:0]    step;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [ADDR_BITS-1:0] chain [CHAIN_DEPTH];
  logic [ADDR_BITS-1:0] pred  [NOUT];
  logic                 flush_q;
  logic                 we_q;
  logic                 exec_q;
  logic [ADDR_BITS-1:0] wsrc_q;
  logic [ADDR_BITS-1:0] wtgt_q;

  logic                 accept;
  logic                 walk_done;
  logic                 out_free;
  logic                 upd_go;
  logic                 refused;
  logic [ADDR_BITS-1:0] lookup_addr;
  logic [ADDR_BITS-1:0] hit_target;
  logic [ADDR_BITS-1:0] next_addr;

  assign in_stall  = (state != btb_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign walk_done = (step == STEP_W'(CHAIN_DEPTH - 1));
  assign out_free  = !out_valid || !out_stall;

  // next state and update control
  always_comb begin
    state_next = state;
    upd_go     = 1'b0;
    case (state)
      btb_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = btb_pkg::ST_WALK;
        end
      end
      btb_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = btb_pkg::ST_UPDATE;
        end
      end
      btb_pkg::ST_UPDATE: begin
        if (out_free) begin
          upd_go     = 1'b1;
          state_next = btb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared lookup port: chain address while walking, write source on update
  assign lookup_addr = (state == btb_pkg::ST_UPDATE) ? wsrc_q : cur_addr;
  assign next_addr   = status.hit ? hit_target
                                  : cur_addr + ADDR_BITS'(btb_pkg::STEP_BYTES);

  // refuse a fetch-side write over an execute-side entry
  assign refused      = status.hit && status.hit_exec && !exec_q;
  assign update.write = upd_go && we_q && !refused;
  assign update.flush = upd_go && flush_q;

  btb_row #(
    .ENTRIES  (ENTRIES),
    .ADDR_BITS(ADDR_BITS)
  ) u_row (
    .clk        (clk),
    .rst        (rst),
    .lookup_addr(lookup_addr),
    .wr_source  (wsrc_q),
    .wr_target  (wtgt_q),
    .wr_exec    (exec_q),
    .update     (update),
    .status     (status),
    .hit_target (hit_target)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      flush_q  <= flush;
      we_q     <= write_enable;
      exec_q   <= write_from_exec;
      wsrc_q   <= write_source;
      wtgt_q   <= write_target;
      cur_addr <= fetch_address;
      chain[0] <= fetch_address;
    end else if (state == btb_pkg::ST_WALK) begin
      cur_addr <= next_addr;
    end
  end

  // chain step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_W'(1);
    end else if (accept) begin
      step <= STEP_W'(1);
    end else if (state == btb_pkg::ST_WALK && !walk_done) begin
      step <= step + STEP_W'(1);
    end
  end

  // chain address store
  for (genvar k = 1; k < CHAIN_DEPTH; k++) begin : g_chain
    always_ff @(posedge clk) begin
      if (state == btb_pkg::ST_WALK && step == STEP_W'(k)) begin
        chain[k] <= next_addr;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar k = 0; k < NOUT; k++) begin : g_pred
    if (k < CHAIN_DEPTH) begin : g_used
      always_ff @(posedge clk) begin
        if (upd_go) begin
          pred[k] <= chain[k];
        end
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        if (upd_go) begin
          pred[k] <= '0;
        end
      end
    end
  end

  assign predicted_0 = pred[0];
  assign predicted_1 = pred[1];
  assign predicted_2 = pred[2];
  assign predicted_3 = pred[3];
  assign predicted_4 = pred[4];

endmodule

// ----- test/tb_branch_target_buffer_predictor.sv -----
// self-checking testbench for the branch target buffer predictor
`timescale 1ns / 100ps

module tb_branch_target_buffer_predictor;

  localparam int ENTRIES     = 8;
  localparam int CHAIN_DEPTH = 5;
  localparam int ADDR_BITS   = 32;
  localparam int RANDOM_REQS = 1000;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [btb_pkg::NUM_OUT-1:0][ADDR_BITS-1:0] chain_t;

  // one fetch request as driven on the input side
  typedef struct {
    bit    drain_first;
    logic  flush;
    logic  wen;
    logic  wexec;
    addr_t wsrc;
    addr_t wtgt;
    addr_t fetch;
  } fetch_req_t;

  logic  clk;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  flush = 1'b0;
  logic  write_enable = 1'b0;
  logic  write_from_exec = 1'b0;
  addr_t write_source = '0;
  addr_t write_target = '0;
  addr_t fetch_address = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  addr_t predicted_0, predicted_1, predicted_2, predicted_3, predicted_4;
  chain_t seen_chain;

  fetch_req_t fetch_reqs[$];
  fetch_req_t cur_req;
  chain_t     expected_chains[$];

  // local copy of the buffer, most recent first
  addr_t btb_src   [ENTRIES];
  addr_t btb_tgt   [ENTRIES];
  bit    btb_exec  [ENTRIES];
  bit    btb_live  [ENTRIES];

  int sent_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int idle_left = 0;
  int stall_left = 0;
  int cycle_cnt = 0;
  bit launch;

  assign seen_chain = {predicted_4, predicted_3, predicted_2, predicted_1, predicted_0};

  branch_target_buffer_predictor #(
    .ENTRIES(ENTRIES),
    .CHAIN_DEPTH(CHAIN_DEPTH),
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .flush(flush),
    .write_enable(write_enable),
    .write_from_exec(write_from_exec),
    .write_source(write_source),
    .write_target(write_target),
    .fetch_address(fetch_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .predicted_0(predicted_0),
    .predicted_1(predicted_1),
    .predicted_2(predicted_2),
    .predicted_3(predicted_3),
    .predicted_4(predicted_4)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // empty every slot of the local buffer
  task automatic clear_btb();
    for (int i = 0; i < ENTRIES; i++) begin
      btb_src[i]  = '1;
      btb_tgt[i]  = '0;
      btb_exec[i] = 1'b0;
      btb_live[i] = 1'b0;
    end
  endtask

  // target of the newest live entry for this address, else the next word
  function automatic addr_t next_fetch(addr_t pc);
    for (int n = 0; n < ENTRIES; n++) begin
      if (btb_live[n] && btb_src[n] == pc) return btb_tgt[n];
    end
    return pc + addr_t'(btb_pkg::STEP_BYTES);
  endfunction

  // chain from the buffer before the update, then insert or flush
  task automatic predict_chain_and_update(fetch_req_t r);
    chain_t c;
    addr_t  pc;
    int     hit;
    int     top;
    pc  = r.fetch;
    hit = -1;
    for (int i = 0; i < btb_pkg::NUM_OUT; i++) begin
      if (i < CHAIN_DEPTH) begin
        c[i] = pc;
        pc   = next_fetch(pc);
      end else begin
        c[i] = '0;
      end
    end
    expected_chains.push_back(c);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (btb_live[i] && btb_src[i] == r.wsrc) hit = i;
    end
    // a fetch-side write may not displace an execute-side entry
    if (r.wen && !(hit >= 0 && btb_exec[hit] && !r.wexec)) begin
      top = (hit >= 0) ? hit : ENTRIES - 1;
      for (int i = top; i > 0; i--) begin
        btb_src[i]  = btb_src[i-1];
        btb_tgt[i]  = btb_tgt[i-1];
        btb_exec[i] = btb_exec[i-1];
        btb_live[i] = btb_live[i-1];
      end
      btb_src[0]  = r.wsrc;
      btb_tgt[0]  = r.wtgt;
      btb_exec[0] = r.wexec;
      btb_live[0] = 1'b1;
    end
    if (r.flush) clear_btb();
  endtask

  // idle length for one request or result: none, long or short
  function automatic int draw_wait(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  task automatic add_req(bit hold, logic fl, logic we, logic wx, addr_t src, addr_t tgt,
                         addr_t pc);
    fetch_req_t r;
    r.drain_first = hold;
    r.flush = fl;
    r.wen   = we;
    r.wexec = wx;
    r.wsrc  = src;
    r.wtgt  = tgt;
    r.fetch = pc;
    fetch_reqs.push_back(r);
  endtask

  // mostly addresses from a small window so entries hit and chain
  function automatic addr_t pick_addr(addr_t base);
    if ($urandom_range(0, 99) < 85) return base + addr_t'(4 * $urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) return '1;
    return addr_t'($urandom);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      launch = 1'b0;
      if (in_valid && !in_stall) begin
        predict_chain_and_update(cur_req);
        sent_cnt++;
        idle_left = draw_wait((sent_cnt / 128) % 3);
      end
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (fetch_reqs.size() > 0 &&
                     !(fetch_reqs[0].drain_first && expected_chains.size() != 0)) begin
          launch = 1'b1;
        end
        if (launch) begin
          cur_req = fetch_reqs.pop_front();
          flush           <= cur_req.flush;
          write_enable    <= cur_req.wen;
          write_from_exec <= cur_req.wexec;
          write_source    <= cur_req.wsrc;
          write_target    <= cur_req.wtgt;
          fetch_address   <= cur_req.fetch;
        end
        in_valid <= launch;
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    chain_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chains.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, seen_chain);
          err_cnt++;
        end else begin
          want = expected_chains.pop_front();
          for (int i = 0; i < btb_pkg::NUM_OUT; i++) begin
            if (seen_chain[i] !== want[i]) begin
              $display("%0t: predicted_%0d expected %h actual %h", $time, i, want[i],
                       seen_chain[i]);
              err_cnt++;
            end
          end
        end
        got_cnt++;
        stall_left = draw_wait((got_cnt / 96 + 1) % 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    addr_t base;
    clear_btb();

    // all ones misses after reset; wrap past the top of the address space
    add_req(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '1);
    add_req(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 32'hFFFF_FFFC);
    // build a chain, then try to override an execute entry from fetch
    add_req(1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_2000, 32'h0000_1000);
    add_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_2000, 32'h0000_3000, 32'h0000_1000);
    add_req(1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_2000, 32'h0000_4000, 32'h0000_1000);
    add_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_2000, 32'h0000_4000, 32'h0000_1000);
    // extreme sources and targets
    add_req(1'b0, 1'b0, 1'b1, 1'b1, '1, 32'h0000_0100, '1);
    add_req(1'b0, 1'b0, 1'b1, 1'b0, '0, '1, '0);
    add_req(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '1);
    // flush together with a write, then see everything miss
    add_req(1'b0, 1'b1, 1'b1, 1'b1, 32'hAAAA_AAA8, 32'h5555_5554, 32'h0000_1000);
    add_req(1'b0, 1'b0, 1'b0, 1'b0, 32'hAAAA_AAA8, '0, 32'h0000_1000);
    // overfill so the oldest entry is dropped
    for (int k = 0; k <= ENTRIES; k++) begin
      add_req(1'b0, 1'b0, 1'b1, k[0], 32'h0000_8000 + 16 * k, 32'h0000_8000 + 16 * (k + 1),
              32'h0000_8000);
    end
    // move a middle entry to the front, self loop, flush alone
    add_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_8040, 32'h0000_8000, 32'h0000_8010);
    add_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_9000, 32'h0000_9000, 32'h0000_9000);
    add_req(1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_9000, '0, 32'h0000_9000);
    add_req(1'b0, 1'b1, 1'b0, 1'b0, 32'h1234_5678, 32'h8765_4320, 32'h0000_9000);

    // random requests over a moving address window
    base = 32'h0000_4000;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 200 == 0) begin
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFE0 : (addr_t'($urandom) & ~32'h3);
      end
      add_req(n == 0 || n == RANDOM_REQS / 2, $urandom_range(0, 39) == 0,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              pick_addr(base), pick_addr(base), pick_addr(base));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (fetch_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_chains.size() != 0) @(posedge clk);
    repeat (4 * (CHAIN_DEPTH + 1)) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
